// ===== rtl/odcube_pkg.sv =====
// odcube_pkg: shared types, format codes and constant tables for the
// ordered dither to 6x6x6 cube pipeline; no dependencies
`default_nettype none

package odcube_pkg;

    typedef enum logic [1:0] {
        FMT_RGB555 = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_RGB888 = 2'd2
    } t_fmt;

    typedef logic [7:0] t_comp;
    typedef logic [5:0] t_thresh;
    typedef logic [2:0] t_level;
    typedef logic [5:0] t_rem;

    localparam int unsigned DIVISOR = 51;

    // 8x8 threshold matrix, addressed by {column_phase, row_phase}
    localparam t_thresh THRESHOLD [64] = '{
        6'd0,  6'd38, 6'd9,  6'd47, 6'd2,  6'd40, 6'd11, 6'd50,
        6'd25, 6'd12, 6'd35, 6'd22, 6'd27, 6'd15, 6'd37, 6'd24,
        6'd6,  6'd44, 6'd3,  6'd41, 6'd8,  6'd47, 6'd5,  6'd43,
        6'd31, 6'd19, 6'd28, 6'd15, 6'd34, 6'd21, 6'd31, 6'd18,
        6'd1,  6'd39, 6'd11, 6'd49, 6'd0,  6'd39, 6'd10, 6'd48,
        6'd27, 6'd14, 6'd36, 6'd23, 6'd26, 6'd13, 6'd35, 6'd23,
        6'd7,  6'd46, 6'd4,  6'd43, 6'd7,  6'd45, 6'd3,  6'd42,
        6'd33, 6'd20, 6'd30, 6'd17, 6'd32, 6'd19, 6'd29, 6'd16
    };

    // level times 36
    function automatic logic [7:0] mul36(input t_level l);
        logic [7:0] p;
        case (l)
            3'd0:    p = 8'd0;
            3'd1:    p = 8'd36;
            3'd2:    p = 8'd72;
            3'd3:    p = 8'd108;
            3'd4:    p = 8'd144;
            3'd5:    p = 8'd180;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

    // level times 6
    function automatic logic [5:0] mul6(input t_level l);
        logic [5:0] p;
        case (l)
            3'd0:    p = 6'd0;
            3'd1:    p = 6'd6;
            3'd2:    p = 6'd12;
            3'd3:    p = 6'd18;
            3'd4:    p = 6'd24;
            3'd5:    p = 6'd30;
            default: p = 6'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/odcube_unpack.sv =====
// odcube_unpack: pixel word to 8-bit red, green, blue per source format,
// plus threshold lookup; uses odcube_pkg
`default_nettype none

module odcube_unpack
    import odcube_pkg::*;
(
    input  wire t_fmt        i_fmt,
    input  wire logic [23:0] i_pixel_word,
    input  wire logic [2:0]  i_column_phase,
    input  wire logic [2:0]  i_row_phase,
    output t_comp            o_red,
    output t_comp            o_green,
    output t_comp            o_blue,
    output t_thresh          o_thresh
);

    always_comb begin
        case (i_fmt)
            FMT_RGB555: begin
                o_red   = {i_pixel_word[14:10], 3'b000};
                o_green = {i_pixel_word[9:5],   3'b000};
                o_blue  = {i_pixel_word[4:0],   3'b000};
            end
            FMT_RGB565: begin
                o_red   = {i_pixel_word[15:11], 3'b000};
                o_green = {i_pixel_word[10:5],  2'b00};
                o_blue  = {i_pixel_word[4:0],   3'b000};
            end
            default: begin
                // packed 8-bit, also the reserved code
                o_red   = i_pixel_word[23:16];
                o_green = i_pixel_word[15:8];
                o_blue  = i_pixel_word[7:0];
            end
        endcase
    end

    assign o_thresh = THRESHOLD[{i_column_phase, i_row_phase}];

endmodule

`default_nettype wire

// ===== rtl/odcube_divmod51.sv =====
// odcube_divmod51: quotient and remainder of an 8-bit component by 51
// through a compare ladder; uses odcube_pkg
`default_nettype none

module odcube_divmod51
    import odcube_pkg::*;
(
    input  wire t_comp i_comp,
    output t_level     o_quot,
    output t_rem       o_rem
);

    logic [7:0] base;

    always_comb begin
        if (i_comp >= 8'(5 * DIVISOR)) begin
            o_quot = 3'd5;
            base   = 8'(5 * DIVISOR);
        end else if (i_comp >= 8'(4 * DIVISOR)) begin
            o_quot = 3'd4;
            base   = 8'(4 * DIVISOR);
        end else if (i_comp >= 8'(3 * DIVISOR)) begin
            o_quot = 3'd3;
            base   = 8'(3 * DIVISOR);
        end else if (i_comp >= 8'(2 * DIVISOR)) begin
            o_quot = 3'd2;
            base   = 8'(2 * DIVISOR);
        end else if (i_comp >= 8'(DIVISOR)) begin
            o_quot = 3'd1;
            base   = 8'(DIVISOR);
        end else begin
            o_quot = 3'd0;
            base   = 8'd0;
        end
    end

    logic [7:0] diff;
    assign diff  = i_comp - base;
    assign o_rem = diff[5:0];

endmodule

`default_nettype wire

// ===== rtl/odcube_cube_index.sv =====
// odcube_cube_index: red*36 + green*6 + blue from three levels
// uses odcube_pkg tables
`default_nettype none

module odcube_cube_index
    import odcube_pkg::*;
(
    input  wire t_level      i_red,
    input  wire t_level      i_green,
    input  wire t_level      i_blue,
    output logic [7:0]       o_index
);

    assign o_index = mul36(i_red) + {2'b00, mul6(i_green)} + {5'b00000, i_blue};

endmodule

`default_nettype wire

// ===== rtl/ordered_dither_rgb_to_cube216_unit.sv =====
// Ordered dither of RGB pixels to a 6x6x6 cube index, four-stage pipeline.
// Uses odcube_pkg, odcube_unpack, odcube_divmod51, odcube_cube_index.
//
// One pixel per clock is accepted and one index delivered per clock
// while the output is not stalled. Register stages: unpack and threshold
// lookup, division by 51, dithered level, cube index. Valid bits move
// with the data and each stage holds while the stage after it is full and
// stalled, so back-pressure on the output costs no items. The format
// register may be written only when the pipeline is empty.
`default_nettype none

module ordered_dither_rgb_to_cube216_unit
    import odcube_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [23:0] i_pixel_word,
    input  wire logic [2:0]  i_column_phase,
    input  wire logic [2:0]  i_row_phase,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_palette_index
);

    localparam int unsigned NSTG = 4;

    t_fmt            r_fmt;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] adv;

    // format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGB888;
        end else if (i_cfg_we) begin
            r_fmt <= t_fmt'(i_cfg_data);
        end
    end

    // stage advance, back to front
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];

    always_comb begin
        n_vld = r_vld;
        if (adv[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1: unpack
    t_comp   un_r, un_g, un_b;
    t_thresh un_t;
    t_comp   r_s1_r, r_s1_g, r_s1_b;
    t_thresh r_s1_t;

    odcube_unpack u_unpack (
        .i_fmt          (r_fmt),
        .i_pixel_word   (i_pixel_word),
        .i_column_phase (i_column_phase),
        .i_row_phase    (i_row_phase),
        .o_red          (un_r),
        .o_green        (un_g),
        .o_blue         (un_b),
        .o_thresh       (un_t)
    );

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_r <= un_r;
            r_s1_g <= un_g;
            r_s1_b <= un_b;
            r_s1_t <= un_t;
        end
    end

    // stage 2: divide by 51
    t_level  dq_r, dq_g, dq_b;
    t_rem    dr_r, dr_g, dr_b;
    t_level  r_s2_qr, r_s2_qg, r_s2_qb;
    t_rem    r_s2_rr, r_s2_rg, r_s2_rb;
    t_thresh r_s2_t;

    odcube_divmod51 u_div_r (.i_comp(r_s1_r), .o_quot(dq_r), .o_rem(dr_r));
    odcube_divmod51 u_div_g (.i_comp(r_s1_g), .o_quot(dq_g), .o_rem(dr_g));
    odcube_divmod51 u_div_b (.i_comp(r_s1_b), .o_quot(dq_b), .o_rem(dr_b));

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_qr <= dq_r;
            r_s2_qg <= dq_g;
            r_s2_qb <= dq_b;
            r_s2_rr <= dr_r;
            r_s2_rg <= dr_g;
            r_s2_rb <= dr_b;
            r_s2_t  <= r_s1_t;
        end
    end

    // stage 3: dithered level
    t_level r_s3_lr, r_s3_lg, r_s3_lb;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_lr <= r_s2_qr + t_level'(r_s2_rr > r_s2_t);
            r_s3_lg <= r_s2_qg + t_level'(r_s2_rg > r_s2_t);
            r_s3_lb <= r_s2_qb + t_level'(r_s2_rb > r_s2_t);
        end
    end

    // stage 4: cube index
    logic [7:0] ci_idx;
    logic [7:0] r_s4_idx;

    odcube_cube_index u_index (
        .i_red   (r_s3_lr),
        .i_green (r_s3_lg),
        .i_blue  (r_s3_lb),
        .o_index (ci_idx)
    );

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_idx <= ci_idx;
        end
    end

    assign o_valid         = r_vld[NSTG-1];
    assign o_palette_index = r_s4_idx;

    // checks
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transfer did not enter first stage");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_rr < 6'd51 && r_s2_rg < 6'd51 && r_s2_rb < 6'd51))
        else $error("remainder not below 51");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s3_lr <= 3'd5 && r_s3_lg <= 3'd5 && r_s3_lb <= 3'd5))
        else $error("dither level above 5");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_palette_index <= 8'd215))
        else $error("palette index above 215");

endmodule

`default_nettype wire

// ===== tb/odcube_dither_checker.sv =====
// odcube_dither_checker: watches the pixel and index channels and the format port,
// predicts each palette index and compares it with the block's output
// depends on odcube_pkg for the format codes
`timescale 1ns / 1ps

module odcube_dither_checker
    import odcube_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_pixel_word,
    input  logic [2:0]  i_column_phase,
    input  logic [2:0]  i_row_phase,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_palette_index,
    output int          o_fail_count,
    output int          o_pending
);

    // threshold per {column_phase, row_phase}
    localparam logic [5:0] DITHER_THRESH [64] = '{
        6'd0,  6'd38, 6'd9,  6'd47, 6'd2,  6'd40, 6'd11, 6'd50,
        6'd25, 6'd12, 6'd35, 6'd22, 6'd27, 6'd15, 6'd37, 6'd24,
        6'd6,  6'd44, 6'd3,  6'd41, 6'd8,  6'd47, 6'd5,  6'd43,
        6'd31, 6'd19, 6'd28, 6'd15, 6'd34, 6'd21, 6'd31, 6'd18,
        6'd1,  6'd39, 6'd11, 6'd49, 6'd0,  6'd39, 6'd10, 6'd48,
        6'd27, 6'd14, 6'd36, 6'd23, 6'd26, 6'd13, 6'd35, 6'd23,
        6'd7,  6'd46, 6'd4,  6'd43, 6'd7,  6'd45, 6'd3,  6'd42,
        6'd33, 6'd20, 6'd30, 6'd17, 6'd32, 6'd19, 6'd29, 6'd16
    };

    logic [1:0] src_fmt;
    logic [7:0] cube_index_q [$];
    int         fail_total = 0;
    int         held = 0;
    int         out_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = held;

    function automatic int comp_level(logic [7:0] c, logic [5:0] t);
        int q;
        int r;
        q = int'(c) / 51;
        r = int'(c) % 51;
        return (r > int'(t)) ? q + 1 : q;
    endfunction

    function automatic logic [7:0] predict_cube_index(logic [1:0] fmt, logic [23:0] w,
                                                      logic [2:0] col, logic [2:0] row);
        logic [7:0] red;
        logic [7:0] grn;
        logic [7:0] blu;
        logic [5:0] t;
        t = DITHER_THRESH[{col, row}];
        case (fmt)
            FMT_RGB555: begin
                red = {w[14:10], 3'b000};
                grn = {w[9:5], 3'b000};
                blu = {w[4:0], 3'b000};
            end
            FMT_RGB565: begin
                red = {w[15:11], 3'b000};
                grn = {w[10:5], 2'b00};
                blu = {w[4:0], 3'b000};
            end
            default: begin
                red = w[23:16];
                grn = w[15:8];
                blu = w[7:0];
            end
        endcase
        return 8'(comp_level(red, t) * 36 + comp_level(grn, t) * 6 + comp_level(blu, t));
    endfunction

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            src_fmt <= FMT_RGB888;
            cube_index_q.delete();
            held = 0;
        end else begin
            // an index leaving at this edge never belongs to a pixel entering at it
            if (i_out_valid && i_out_ready) begin
                out_count++;
                if (cube_index_q.size() == 0) begin
                    if (fail_total < 10)
                        $display("[%0t] unexpected index %0d at output transfer %0d",
                                 $realtime, i_palette_index, out_count);
                    fail_total++;
                end else begin
                    want = cube_index_q.pop_front();
                    if (want !== i_palette_index) begin
                        if (fail_total < 10)
                            $display("[%0t] output transfer %0d: palette_index exp %0d got %0d",
                                     $realtime, out_count, want, i_palette_index);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                cube_index_q.push_back(predict_cube_index(src_fmt, i_pixel_word,
                                                          i_column_phase, i_row_phase));
            if (i_cfg_we)
                src_fmt <= i_cfg_data;
            held = cube_index_q.size();
        end
    end

endmodule

// ===== tb/tb_ordered_dither_rgb_to_cube216_unit.sv =====
// tb_ordered_dither_rgb_to_cube216_unit: drives pixels and format writes into the
// dither unit with random gaps and output stalls; verdict from odcube_dither_checker
// depends on odcube_pkg, the dut and odcube_dither_checker
`timescale 1ns / 1ps

module tb_ordered_dither_rgb_to_cube216_unit;
    import odcube_pkg::*;

    localparam logic [1:0] FMT_RESERVED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [23:0] i_pixel_word;
    logic [2:0]  i_column_phase;
    logic [2:0]  i_row_phase;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_palette_index;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int stall_left = 0;
    bit rx_free = 1'b0;
    bit tx_burst = 1'b0;
    logic [1:0] cur_fmt = FMT_RGB888;

    ordered_dither_rgb_to_cube216_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pixel_word    (i_pixel_word),
        .i_column_phase  (i_column_phase),
        .i_row_phase     (i_row_phase),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_palette_index (o_palette_index)
    );

    odcube_dither_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_pixel_word    (i_pixel_word),
        .i_column_phase  (i_column_phase),
        .i_row_phase     (i_row_phase),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_palette_index (o_palette_index),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // 8-bit component, often at or next to a multiple of 51
    function automatic logic [7:0] pick_component();
        int k;
        int v;
        if ($urandom_range(0, 2) != 0)
            return 8'($urandom_range(0, 255));
        k = $urandom_range(0, 5);
        v = k * 51 + $urandom_range(0, 2) - 1;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // output side stalls
    always @(posedge i_clk) begin
        int n;
        if (rx_free || !i_rst_n) begin
            i_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            n = gap_len();
            i_ready <= (n == 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("** ordered_dither_rgb_to_cube216_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_pixel(logic [23:0] w, logic [2:0] col, logic [2:0] row);
        int n;
        i_valid <= 1'b1;
        i_pixel_word <= w;
        i_column_phase <= col;
        i_row_phase <= row;
        @(negedge i_clk);
        while (!o_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        n = tx_burst ? 0 : gap_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every index is out
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_format(logic [1:0] f);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= f;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_fmt = f;
    endtask

    initial begin
        logic [1:0] phase_fmt [8];
        int pause_at;
        logic [23:0] w;

        phase_fmt = '{FMT_RGB555, FMT_RGB565, FMT_RGB888, FMT_RESERVED,
                      FMT_RGB888, FMT_RGB565, FMT_RGB555, FMT_RGB888};

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_pixel_word <= '0;
        i_column_phase <= '0;
        i_row_phase <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // packed 8-bit from reset: remainder at and around the thresholds
        send_pixel(24'h000000, 3'd0, 3'd0);
        send_pixel(24'hFFFFFF, 3'd7, 3'd7);
        send_pixel(24'h333333, 3'd0, 3'd0);
        send_pixel(24'h323232, 3'd0, 3'd7);
        send_pixel(24'h323232, 3'd0, 3'd1);
        send_pixel(24'hFF0080, 3'd4, 3'd4);
        send_pixel(24'h01FE34, 3'd3, 3'd7);

        // rgb555 with the unused upper bits set
        write_format(FMT_RGB555);
        send_pixel(24'h000000, 3'd0, 3'd0);
        send_pixel(24'h007FFF, 3'd7, 3'd7);
        send_pixel(24'hFF8000, 3'd0, 3'd0);
        send_pixel(24'hFFFFFF, 3'd0, 3'd7);

        write_format(FMT_RGB565);
        send_pixel(24'h00FFFF, 3'd7, 3'd7);
        send_pixel(24'hFF0000, 3'd0, 3'd0);
        send_pixel(24'h00F81F, 3'd4, 3'd4);
        send_pixel(24'hFF07E0, 3'd7, 3'd0);

        // reserved code acts as packed 8-bit
        write_format(FMT_RESERVED);
        send_pixel(24'hFFFFFF, 3'd3, 3'd3);
        send_pixel(24'h000000, 3'd0, 3'd0);
        send_pixel(24'h333333, 3'd4, 3'd4);
        send_pixel(24'h663399, 3'd0, 3'd7);

        for (int p = 0; p < 8; p++) begin
            write_format(phase_fmt[p]);
            rx_free <= ($urandom_range(0, 3) == 0);
            tx_burst = ($urandom_range(0, 3) == 0);
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == pause_at)
                    drain();
                if (cur_fmt == FMT_RGB555 || cur_fmt == FMT_RGB565)
                    w = 24'($urandom);
                else
                    w = {pick_component(), pick_component(), pick_component()};
                send_pixel(w, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end
        end

        rx_free <= 1'b0;
        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** ordered_dither_rgb_to_cube216_unit: PASSED **");
        else
            $display("** ordered_dither_rgb_to_cube216_unit: FAILED **");
        $finish;
    end

endmodule

// ===== ordered_dither_rgb_to_cube216_unit.f =====
rtl/odcube_pkg.sv
rtl/odcube_unpack.sv
rtl/odcube_divmod51.sv
rtl/odcube_cube_index.sv
rtl/ordered_dither_rgb_to_cube216_unit.sv
tb/odcube_dither_checker.sv
tb/tb_ordered_dither_rgb_to_cube216_unit.sv
